### design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants and types for the sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int NUM_CFG = 6;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_TEMP_CAL    = 3'd0,
    REG_PRESS_CAL_A = 3'd1,
    REG_PRESS_CAL_B = 3'd2,
    REG_PRESS_CAL_C = 3'd3,
    REG_HUM_CAL_A   = 3'd4,
    REG_HUM_CAL_B   = 3'd5
  } cfg_reg_t;

  // division unit request bundle
  typedef struct packed {
    logic        valid;
    logic [31:0] num;
    logic [31:0] den;
    logic        dbl_after;
  } div_req_t;

  localparam int DIV_STAGES = 32;

  // arithmetic shift right of a 32-bit pattern
  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    asr = 32'($signed(x) >>> n);
  endfunction

  // 32x32 wrapping multiply (low 32 bits)
  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    mul = p[31:0];
  endfunction

endpackage

### design/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esc_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [31:0]            num,
  input  logic [31:0]            den,
  input  logic                   dbl_after,
  output logic [31:0]            quo
);

  localparam int N = esc_pkg::DIV_STAGES;

  logic [31:0] rem_q [N+1];
  logic [31:0] quo_q [N+1];
  logic [31:0] den_q [N+1];
  logic        dbl_q [N+1];

  assign rem_q[0] = '0;
  assign quo_q[0] = num;
  assign den_q[0] = den;
  assign dbl_q[0] = dbl_after;

  // one quotient bit per stage, shifting the dividend out from the top
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] shifted;
    assign shifted = {rem_q[s], quo_q[s][31]};
    assign trial   = shifted - {1'b0, den_q[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[32]) begin
          rem_q[s+1] <= trial[31:0];
          quo_q[s+1] <= {quo_q[s][30:0], 1'b1};
        end else begin
          rem_q[s+1] <= shifted[31:0];
          quo_q[s+1] <= {quo_q[s][30:0], 1'b0};
        end
        den_q[s+1] <= den_q[s];
        dbl_q[s+1] <= dbl_q[s];
      end
    end
  end

  assign quo = dbl_q[N] ? {quo_q[N][30:0], 1'b0} : quo_q[N];

  `ASSERT_NEXT(a_div_rem_below, clk, rst, en && den_q[N-1] != '0, rem_q[N] < den_q[N])

endmodule

### design/environmental_sensor_compensation.sv
// ----------------------------------------------------------------------------
// environmental_sensor_compensation
// 32-bit integer temperature / pressure / humidity compensation pipeline.
// ----------------------------------------------------------------------------
// channel   | dir | contents
// s_axis    | in  | raw_temperature, raw_pressure, raw_humidity
// m_axis    | out | fine, centi, pressure, invalid flag, humidity
// cfg       | in  | calibration register writes
//
// One word per cycle when not stalled. The path is 7 stages ahead of the divider,
// its 32 stages, a pressure correction stage and the output register.
// All stages advance together on a global enable (!m_axis_tvalid || m_axis_tready).
// rst clears the valid bits and the calibration registers.
// A stall freezes every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module environmental_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [19:0] raw_temperature, [39:20] raw_pressure, [55:40] raw_humidity
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] fine_temperature, [63:32] temperature_centi, [95:64] pressure_pa,
  // [96] pressure_invalid, [113:97] humidity_q10, [119:114] zero
  output logic [119:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [esc_pkg::IDX_W-1:0] cfg_index,
  input  logic [esc_pkg::CFG_W-1:0] cfg_data
);

  localparam int NS = 8 + esc_pkg::DIV_STAGES + 1;

  logic [47:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  logic [39:0] hum_cal_a;
  logic [23:0] hum_cal_b;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal <= '0; press_cal_a <= '0; press_cal_b <= '0;
      press_cal_c <= '0; hum_cal_a <= '0; hum_cal_b <= '0;
    end else if (cfg_we) begin
      unique case (esc_pkg::cfg_reg_t'(cfg_index))
        esc_pkg::REG_TEMP_CAL:    temp_cal    <= cfg_data;
        esc_pkg::REG_PRESS_CAL_A: press_cal_a <= cfg_data;
        esc_pkg::REG_PRESS_CAL_B: press_cal_b <= cfg_data;
        esc_pkg::REG_PRESS_CAL_C: press_cal_c <= cfg_data;
        esc_pkg::REG_HUM_CAL_A:   hum_cal_a   <= cfg_data[39:0];
        esc_pkg::REG_HUM_CAL_B:   hum_cal_b   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // calibration fields
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, temp_cal[15:0]};
  assign t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
  assign t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
  assign p1 = {16'd0, press_cal_a[15:0]};
  assign p2 = {{16{press_cal_a[31]}}, press_cal_a[31:16]};
  assign p3 = {{16{press_cal_a[47]}}, press_cal_a[47:32]};
  assign p4 = {{16{press_cal_b[15]}}, press_cal_b[15:0]};
  assign p5 = {{16{press_cal_b[31]}}, press_cal_b[31:16]};
  assign p6 = {{16{press_cal_b[47]}}, press_cal_b[47:32]};
  assign p7 = {{16{press_cal_c[15]}}, press_cal_c[15:0]};
  assign p8 = {{16{press_cal_c[31]}}, press_cal_c[31:16]};
  assign p9 = {{16{press_cal_c[47]}}, press_cal_c[47:32]};
  assign h1 = {24'd0, hum_cal_a[7:0]};
  assign h2 = {{16{hum_cal_a[23]}}, hum_cal_a[23:8]};
  assign h3 = {24'd0, hum_cal_a[31:24]};
  assign h6 = {{24{hum_cal_a[39]}}, hum_cal_a[39:32]};
  assign h4 = {{20{hum_cal_b[11]}}, hum_cal_b[11:0]};
  assign h5 = {{20{hum_cal_b[23]}}, hum_cal_b[23:12]};

  // global advance and valid chain
  logic en;
  logic [NS-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NS-2:0], s_axis_tvalid};
  end

  // ---- stage 1: input and first products
  logic [31:0] s1_ap, s1_ah, s1_ta, s1_d;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ap <= {12'd0, s_axis_tdata[39:20]};
      s1_ah <= {16'd0, s_axis_tdata[55:40]};
      s1_ta <= esc_pkg::mul({15'd0, s_axis_tdata[19:3]} - (t1 << 1), t2);
      s1_d  <= {16'd0, s_axis_tdata[19:4]} - t1;
    end
  end

  // ---- stage 2: d*d
  logic [31:0] s2_ap, s2_ah, s2_a, s2_dd;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_ap <= s1_ap; s2_ah <= s1_ah;
      s2_a  <= esc_pkg::asr(s1_ta, 11);
      s2_dd <= esc_pkg::asr(esc_pkg::mul(s1_d, s1_d), 12);
    end
  end

  // ---- stage 3: fine temperature
  logic [31:0] s3_ap, s3_ah, s3_fine;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_ap <= s2_ap; s3_ah <= s2_ah;
      s3_fine <= s2_a + esc_pkg::asr(esc_pkg::mul(s2_dd, t3), 14);
    end
  end

  // ---- stage 4: pressure/humidity first products
  logic [31:0] s4_ap, s4_ah, s4_fine, s4_tc, s4_pdd, s4_pa5, s4_pa2;
  logic [31:0] s4_hb, s4_h6, s4_h3;
  logic [31:0] c4_a, c4_d, c4_ha;
  always_comb begin
    c4_a  = esc_pkg::asr(s3_fine, 1) - 32'd64000;
    c4_d  = esc_pkg::asr(c4_a, 2);
    c4_ha = s3_fine - 32'd76800;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_ap <= s3_ap; s4_ah <= s3_ah; s4_fine <= s3_fine;
      s4_tc  <= esc_pkg::asr(esc_pkg::mul(s3_fine, 32'd5) + 32'd128, 8);
      s4_pdd <= esc_pkg::mul(c4_d, c4_d);
      s4_pa5 <= esc_pkg::mul(c4_a, p5);
      s4_pa2 <= esc_pkg::mul(p2, c4_a);
      s4_hb  <= esc_pkg::mul(h5, c4_ha);
      s4_h6  <= esc_pkg::asr(esc_pkg::mul(c4_ha, h6), 10);
      s4_h3  <= esc_pkg::asr(esc_pkg::mul(c4_ha, h3), 11) + 32'd32768;
    end
  end

  // ---- stage 5
  logic [31:0] s5_ap, s5_fine, s5_tc, s5_b, s5_a3, s5_hb, s5_hd;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_ap <= s4_ap; s5_fine <= s4_fine; s5_tc <= s4_tc;
      s5_b  <= esc_pkg::mul(esc_pkg::asr(s4_pdd, 11), p6) + (s4_pa5 << 1);
      s5_a3 <= esc_pkg::asr(esc_pkg::mul(p3, esc_pkg::asr(s4_pdd, 13)), 3)
               + esc_pkg::asr(s4_pa2, 1);
      s5_hb <= esc_pkg::asr(((s4_ah << 14) - (h4 << 20) - s4_hb) + 32'd16384, 15);
      s5_hd <= esc_pkg::asr(esc_pkg::mul(s4_h6, s4_h3), 10) + 32'd2097152;
    end
  end

  // ---- stage 6
  logic [31:0] s6_ap, s6_fine, s6_tc, s6_b, s6_a, s6_hb, s6_hd;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_ap <= s5_ap; s6_fine <= s5_fine; s6_tc <= s5_tc;
      s6_b  <= esc_pkg::asr(s5_b, 2) + (p4 << 16);
      s6_a  <= esc_pkg::asr(esc_pkg::mul(32'd32768 + esc_pkg::asr(s5_a3, 18), p1), 15);
      s6_hb <= s5_hb;
      s6_hd <= esc_pkg::asr(esc_pkg::mul(s5_hd, h2) + 32'd8192, 14);
    end
  end

  // ---- stage 7: dividend and humidity product
  logic [31:0] s7_fine, s7_tc, s7_num, s7_den, s7_hum;
  logic        s7_dbl, s7_inv;
  logic [31:0] c7_p;
  assign c7_p = esc_pkg::mul((32'd1048576 - s6_ap) - esc_pkg::asr(s6_b, 12), 32'd3125);
  always_ff @(posedge clk) begin
    if (en) begin
      s7_fine <= s6_fine; s7_tc <= s6_tc;
      s7_inv  <= (s6_a == '0);
      s7_den  <= s6_a;
      s7_dbl  <= c7_p[31];
      s7_num  <= c7_p[31] ? c7_p : (c7_p << 1);
      s7_hum  <= esc_pkg::mul(s6_hb, s6_hd);
    end
  end

  // ---- stage 8: humidity square term
  logic [31:0] s8_fine, s8_tc, s8_hum, s8_hdd;
  logic        s8_inv;
  logic [31:0] c8_d;
  assign c8_d = esc_pkg::asr(s7_hum, 15);
  always_ff @(posedge clk) begin
    if (en) begin
      s8_fine <= s7_fine; s8_tc <= s7_tc; s8_inv <= s7_inv;
      s8_hum  <= s7_hum;
      s8_hdd  <= esc_pkg::asr(esc_pkg::mul(c8_d, c8_d), 7);
    end
  end

  // humidity finish and clamp, entering the delay line
  logic [31:0] c9_a;
  logic [16:0] c9_hum;
  always_comb begin
    c9_a = s8_hum - esc_pkg::asr(esc_pkg::mul(s8_hdd, h1), 4);
    if (c9_a[31]) c9_hum = '0;
    else if (c9_a > 32'd419430400) c9_hum = 17'd102400;
    else c9_hum = c9_a[28:12];
  end

  // ---- divider with side-band delay line
  logic [31:0] quo;
  esc_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .num(s7_num), .den(s7_den), .dbl_after(s7_dbl), .quo(quo)
  );

  localparam int DL = esc_pkg::DIV_STAGES - 1;
  logic [31:0] dl_fine [DL], dl_tc [DL];
  logic [16:0] dl_hum [DL];
  logic        dl_inv [DL];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_fine[0] <= s8_fine; dl_tc[0] <= s8_tc;
      dl_hum[0] <= c9_hum; dl_inv[0] <= s8_inv;
      for (int i = 1; i < DL; i++) begin
        dl_fine[i] <= dl_fine[i-1]; dl_tc[i] <= dl_tc[i-1];
        dl_hum[i] <= dl_hum[i-1]; dl_inv[i] <= dl_inv[i-1];
      end
    end
  end

  // ---- pressure correction products
  logic [31:0] f1_p, f1_dd, f1_b, f1_fine, f1_tc;
  logic [16:0] f1_hum;
  logic        f1_inv;
  logic [31:0] cf_d;
  assign cf_d = quo >> 3;
  always_ff @(posedge clk) begin
    if (en) begin
      f1_p  <= quo;
      f1_dd <= esc_pkg::mul(cf_d, cf_d) >> 13;
      f1_b  <= esc_pkg::asr(esc_pkg::mul(quo >> 2, p8), 13);
      f1_fine <= dl_fine[DL-1]; f1_tc <= dl_tc[DL-1];
      f1_hum <= dl_hum[DL-1]; f1_inv <= dl_inv[DL-1];
    end
  end

  // ---- output register
  logic [31:0] co_a;
  assign co_a = esc_pkg::asr(esc_pkg::mul(p9, f1_dd), 12);
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata[31:0]    <= f1_fine;
      m_axis_tdata[63:32]   <= f1_tc;
      m_axis_tdata[95:64]   <= f1_inv ? '0 : f1_p + esc_pkg::asr(co_a + f1_b + p7, 4);
      m_axis_tdata[96]      <= f1_inv;
      m_axis_tdata[113:97]  <= f1_hum;
      m_axis_tdata[119:114] <= '0;
    end
  end

  `ASSERT_NEXT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPL(a_ready_when_free, clk, rst, !m_axis_tvalid, s_axis_tready)
  `ASSERT_IMPL(a_hum_range, clk, rst, m_axis_tvalid, m_axis_tdata[113:97] <= 17'd102400)
  `ASSERT_IMPL(a_invalid_zero, clk, rst, m_axis_tvalid && m_axis_tdata[96], ~|m_axis_tdata[95:64])

endmodule
